// ===== src/olid_pkg.sv =====
// Package for the ordered list block: widths, request and status codes, sequencer states, result bundle.
package olid_pkg;

   localparam int DEPTH_DEF = 256;
   localparam int DATA_W    = 32;
   localparam int POS_W     = 8;
   localparam int CNT_W     = 9;
   localparam int REQ_W     = 3;
   localparam int STAT_W    = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT = 3'd0,
      REQ_APPEND = 3'd1,
      REQ_DELETE = 3'd2,
      REQ_REMOVE = 3'd3,
      REQ_READ   = 3'd4
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_BADPOS   = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP,
      S_DOWN,
      S_SEARCH,
      S_READ,
      S_RDWAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      status_type               status;
      logic [CNT_W-1:0]         count;
   } res_type;

endpackage

// ===== src/olid_ram.sv =====
// Entry store: one write port, one read port with registered read data.
module olid_ram import olid_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH)-1:0]   waddr,
   input  logic [DATA_W-1:0]          wdata,
   input  logic [$clog2(DEPTH)-1:0]   raddr,
   output logic [DATA_W-1:0]          rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/olid_ctrl.sv =====
// Sequencer: decodes a request and walks the store one entry per cycle.
module olid_ctrl import olid_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [REQ_W-1:0]           req_type,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       res_valid,
   input  logic                       res_taken,
   output res_type                    res,
   output logic                       mem_we,
   output logic [$clog2(DEPTH)-1:0]   mem_waddr,
   output logic [DATA_W-1:0]          mem_wdata,
   output logic [$clog2(DEPTH)-1:0]   mem_raddr,
   input  logic [DATA_W-1:0]          mem_rdata
);

   localparam int IW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int CW = (LW > POS_W) ? LW : POS_W;

   state_type                state_ff, state_in;
   logic [LW-1:0]            len_ff, len_in;
   logic                     pend_ff, pend_in;
   logic [LW-1:0]            cur_ff, cur_in;
   logic [LW-1:0]            pos_ff, pos_in;
   logic [IW-1:0]            wr_ff, wr_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] rd_ff, rd_in;
   status_type               st_ff, st_in;

   logic [CW-1:0] pos_ext, len_ext, tgt_ext;
   logic [LW-1:0] nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      pos_ff <= pos_in;
      wr_ff  <= wr_in;
      val_ff <= val_in;
      rd_ff  <= rd_in;
      st_ff  <= st_in;
   end

   assign pos_ext = CW'(req_position);
   assign len_ext = CW'(len_ff);
   assign nxt     = cur_ff + 1'b1;

   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      pend_in   = 1'b0;
      cur_in    = cur_ff;
      pos_in    = pos_ff;
      wr_in     = wr_ff;
      val_in    = val_ff;
      rd_in     = rd_ff;
      st_in     = st_ff;
      mem_we    = 1'b0;
      mem_waddr = wr_ff;
      mem_wdata = mem_rdata;
      mem_raddr = IW'(cur_ff);
      tgt_ext   = pos_ext;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rd_in  = '0;
               st_in  = STAT_OK;
               val_in = req_value;
               cur_in = '0;
               case (req_code_type'(req_type))
                  REQ_INSERT, REQ_APPEND: begin
                     if (req_code_type'(req_type) == REQ_APPEND) begin
                        tgt_ext = len_ext;
                     end
                     if (len_ff == LW'(DEPTH)) begin
                        st_in    = STAT_FULL;
                        state_in = S_DONE;
                     end else if (tgt_ext > len_ext) begin
                        st_in    = STAT_BADPOS;
                        state_in = S_DONE;
                     end else begin
                        pos_in   = LW'(tgt_ext);
                        cur_in   = len_ff;
                        state_in = S_UP;
                     end
                  end
                  REQ_DELETE: begin
                     if (pos_ext >= len_ext) begin
                        st_in    = STAT_BADPOS;
                        state_in = S_DONE;
                     end else begin
                        cur_in   = LW'(pos_ext);
                        state_in = S_DOWN;
                     end
                  end
                  REQ_REMOVE: begin
                     state_in = S_SEARCH;
                  end
                  REQ_READ: begin
                     if (pos_ext >= len_ext) begin
                        st_in    = STAT_BADPOS;
                        state_in = S_DONE;
                     end else begin
                        pos_in   = LW'(pos_ext);
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // shift up: read k-1, write it to k in the next cycle
         S_UP: begin
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (cur_ff != pos_ff) begin
               mem_raddr = IW'(cur_ff - 1'b1);
               pend_in   = 1'b1;
               wr_in     = IW'(cur_ff);
               cur_in    = cur_ff - 1'b1;
            end else if (!pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = IW'(pos_ff);
               mem_wdata = val_ff;
               len_in    = len_ff + 1'b1;
               state_in  = S_DONE;
            end
         end

         // shift down: read k+1, write it to k in the next cycle
         S_DOWN: begin
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (nxt < len_ff) begin
               mem_raddr = IW'(nxt);
               pend_in   = 1'b1;
               wr_in     = IW'(cur_ff);
               cur_in    = nxt;
            end else if (!pend_ff) begin
               len_in   = len_ff - 1'b1;
               state_in = S_DONE;
            end
         end

         // linear search; wr_ff tags the entry whose data is in mem_rdata
         S_SEARCH: begin
            if (pend_ff && (mem_rdata == val_ff)) begin
               cur_in   = LW'(wr_ff);
               state_in = S_DOWN;
            end else if (cur_ff < len_ff) begin
               mem_raddr = IW'(cur_ff);
               pend_in   = 1'b1;
               wr_in     = IW'(cur_ff);
               cur_in    = nxt;
            end else if (!pend_ff) begin
               st_in    = STAT_NOTFOUND;
               state_in = S_DONE;
            end
         end

         S_READ: begin
            mem_raddr = IW'(pos_ff);
            state_in  = S_RDWAIT;
         end

         S_RDWAIT: begin
            rd_in    = mem_rdata;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (res_taken) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign res_valid      = (state_ff == S_DONE);
   assign res.read_value = rd_ff;
   assign res.status     = st_ff;
   assign res.count      = CNT_W'(len_ff);

endmodule

// ===== src/ordered_list_insert_delete.sv =====
// Top level of the ordered list: sequencer, entry store and result register.
//
// Ordered list of signed 32-bit words held in a DEPTH-entry store with a length count.
// Request channel (req_valid / req_stall, fields req_type, req_position, req_value):
//   insert at a position, append, delete at a position, remove first equal value, read.
// Result channel (rsp_valid / rsp_stall): one transfer per request with rsp_read_value,
//   rsp_status (ok, full, bad position, not found) and rsp_count, the new length.
// One request is worked at a time; req_stall stays high from the accepting edge until
// the result has moved into the output register.
// Insert shifts each entry from the position upward by one slot before writing the value;
//   delete shifts each entry above the position down by one; remove searches from the
//   start, then deletes the first match. The next request is taken only after the
//   handoff, so one request must finish before another is accepted.
// The walks are bound by the single store port pair: one read and one write per cycle,
//   with registered read data in every walk.
// Rejected and unknown requests go straight to the result with the list unchanged.
// Reset (synchronous, active high) empties the list and clears both valids; the store
//   itself is not cleared, as only entries below the length are ever read.
// While rsp_stall holds, the result waits in the output register and the next request
//   can be accepted and worked; it finishes once the register frees up.
module ordered_list_insert_delete import olid_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [REQ_W-1:0]           req_type,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [DATA_W-1:0]   rsp_read_value,
   output logic [STAT_W-1:0]          rsp_status,
   output logic [CNT_W-1:0]           rsp_count
);

   localparam int IW = $clog2(DEPTH);

   logic                       res_valid;
   logic                       res_taken;
   res_type                    res;
   logic                       mem_we;
   logic [IW-1:0]              mem_waddr;
   logic [DATA_W-1:0]          mem_wdata;
   logic [IW-1:0]              mem_raddr;
   logic [DATA_W-1:0]          mem_rdata;

   logic                       rsp_valid_ff;
   logic signed [DATA_W-1:0]   rsp_read_value_ff;
   status_type                 rsp_status_ff;
   logic [CNT_W-1:0]           rsp_count_ff;

   olid_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_position (req_position),
      .req_value    (req_value),
      .res_valid    (res_valid),
      .res_taken    (res_taken),
      .res          (res),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata)
   );

   olid_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // output register is free when empty or being drained this cycle
   assign res_taken = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_taken) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload loads only on a handoff, so a stalled transfer holds steady
   always_ff @(posedge clock) begin
      if (res_valid && res_taken) begin
         rsp_read_value_ff <= res.read_value;
         rsp_status_ff     <= res.status;
         rsp_count_ff      <= res.count;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

endmodule
